// ===== sv/rmvg_pkg.sv =====
// Shared types, constants and arithmetic helpers for the ring mesh vertex generator.
package rmvg_pkg;

  localparam int INDEX_BITS_DEF   = 12;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  localparam int DIV_W   = 13;  // divisions register
  localparam int RAD_W   = 16;  // radius registers, Q8.8
  localparam int QUO_W   = 33;  // floor(k * 2^32 / d), reaches 2^32 on the closing step
  localparam int PH_W    = 32;
  localparam int CW      = 33;  // CORDIC datapath, Q2.30 plus headroom
  localparam int TRIG_W  = 17;  // Q1.15 held so that 1.0 is exact
  localparam int U_W     = 17;
  localparam int VN_W    = 15;
  localparam int POS_W   = 17;
  localparam int PROD_W  = 34;
  localparam int CMP_W   = 17;  // wide enough for any index and divisions
  localparam int SLOT_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int VERTS_PER_SEG = 6;
  localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_DIVISIONS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 2'd2;

  localparam logic [DIV_W-1:0] DIVISIONS_RST    = 13'd32;
  localparam logic [RAD_W-1:0] OUTER_RADIUS_RST = 16'd256;
  localparam logic [RAD_W-1:0] INNER_RADIUS_RST = 16'd128;

  // pi * 2^30 split into two 16-bit halves for the phase-to-radian product
  localparam logic [15:0] PI_Q30_HI = 16'hC90F;
  localparam logic [15:0] PI_Q30_LO = 16'hDAA2;
  localparam logic [CW-1:0] CORDIC_GAIN_Q30 = 33'd652032874;

  typedef struct packed {
    logic [VN_W-1:0] vnum;  // segment index times six
    logic            hi;    // second angle of the segment
    logic            bad;
  } meta_t;

  typedef struct packed {
    logic             v;
    meta_t            m;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_st_t;

  typedef struct packed {
    logic           v;
    meta_t          m;
    logic [1:0]     quad;
    logic [U_W-1:0] u;
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic [CW-1:0]  z;
  } cor_st_t;

  typedef struct packed {
    logic              v;
    meta_t             m;
    logic [TRIG_W-1:0] s;
    logic [TRIG_W-1:0] c;
    logic [U_W-1:0]    u;
  } trig_t;

  function automatic logic [CW-1:0] atan_q30(input int i);
    logic [CW-1:0] a;
    case (i)
      0:  a = 33'd843314856;
      1:  a = 33'd497837829;
      2:  a = 33'd263043836;
      3:  a = 33'd133525158;
      4:  a = 33'd67021686;
      5:  a = 33'd33543515;
      6:  a = 33'd16775850;
      7:  a = 33'd8388437;
      8:  a = 33'd4194282;
      9:  a = 33'd2097149;
      10: a = 33'd1048575;
      11: a = 33'd524287;
      12: a = 33'd262143;
      13: a = 33'd131071;
      14: a = 33'd65535;
      15: a = 33'd32767;
      16: a = 33'd16383;
      17: a = 33'd8191;
      18: a = 33'd4095;
      19: a = 33'd2047;
      20: a = 33'd1023;
      21: a = 33'd511;
      22: a = 33'd255;
      23: a = 33'd127;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q2.30 to Q1.15, round half up, clamp to +-1.0
  function automatic logic [TRIG_W-1:0] round_trig(input logic [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    logic [TRIG_W-1:0]    o;
    t = $signed(v) + $signed(CW'(16384));
    r = t >>> 15;
    if (r > $signed(CW'(32768)))
      o = 17'h08000;
    else if (r < -$signed(CW'(32768)))
      o = 17'h18000;
    else
      o = r[TRIG_W-1:0];
    return o;
  endfunction

  // Q.23 product to Q8.8, round half up, clamp to +-65535
  function automatic logic [POS_W-1:0] round_pos(input logic [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] r;
    logic [POS_W-1:0]         o;
    t = $signed(p) + $signed(PROD_W'(16384));
    r = t >>> 15;
    if (r > $signed(PROD_W'(65535)))
      o = 17'h0FFFF;
    else if (r < -$signed(PROD_W'(65535)))
      o = 17'h10001;
    else
      o = r[POS_W-1:0];
    return o;
  endfunction

  // Slot order: outer(k), outer(k+1), inner(k), inner(k), outer(k+1), inner(k+1)
  function automatic logic slot_step(input logic [SLOT_W-1:0] s);
    logic b;
    case (s)
      3'd1, 3'd4, 3'd5: b = 1'b1;
      default:          b = 1'b0;
    endcase
    return b;
  endfunction

  function automatic logic slot_inner(input logic [SLOT_W-1:0] s);
    logic b;
    case (s)
      3'd2, 3'd3, 3'd5: b = 1'b1;
      default:          b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/rmvg_if.sv =====
// Stream and configuration channel interfaces of the ring mesh vertex generator.
interface rmvg_in_if #(parameter int IndexBits = 12);
  logic                 valid;
  logic                 ready;
  logic [IndexBits-1:0] segment_index;
  modport source (output valid, output segment_index, input ready);
  modport sink (input valid, input segment_index, output ready);
endinterface

interface rmvg_out_if;
  logic               valid;
  logic               ready;
  logic [14:0]        vertex_number;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic [16:0]        tex_u;
  logic               tex_v;
  logic               bad_index;
  logic               last;
  modport source (output valid, output vertex_number, output pos_x, output pos_y,
                  output tex_u, output tex_v, output bad_index, output last, input ready);
  modport sink (input valid, input vertex_number, input pos_x, input pos_y,
                input tex_u, input tex_v, input bad_index, input last, output ready);
endinterface

interface rmvg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/rmvg_div_cell.sv =====
// One restoring-division cell: produces one bit of floor(k * 2^32 / divisions).
module rmvg_div_cell
  import rmvg_pkg::*;
#(
  parameter bit FirstCell = 1'b0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [DIV_W-1:0] divisor,
  input  div_st_t          prev,
  output div_st_t          cur
);

  div_st_t        cur_r;
  div_st_t        cur_nxt;
  logic [DIV_W:0] dbl;
  logic           ge;

  always_comb begin
    // first cell takes the integer bit, the rest shift the remainder up
    dbl = FirstCell ? {1'b0, prev.rem} : {prev.rem, 1'b0};
    ge  = dbl >= {1'b0, divisor};
    cur_nxt     = prev;
    cur_nxt.rem = ge ? DIV_W'(dbl - {1'b0, divisor}) : dbl[DIV_W-1:0];
    cur_nxt.quo = {prev.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.v <= 1'b0;
    end else if (adv) begin
      cur_r <= cur_nxt;
    end
  end

  assign cur = cur_r;

endmodule

// ===== sv/rmvg_cordic_cell.sv =====
// One rotation-mode CORDIC cell with a fixed shift and arctangent constant.
module rmvg_cordic_cell
  import rmvg_pkg::*;
#(
  parameter int Step = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  cor_st_t prev,
  output cor_st_t cur
);

  localparam logic [CW-1:0] ATAN = atan_q30(Step);

  cor_st_t       cur_r;
  cor_st_t       cur_nxt;
  logic [CW-1:0] xs;
  logic [CW-1:0] ys;

  always_comb begin
    xs = $signed(prev.x) >>> Step;
    ys = $signed(prev.y) >>> Step;
    cur_nxt = prev;
    if (!prev.z[CW-1]) begin
      cur_nxt.x = prev.x - ys;
      cur_nxt.y = prev.y + xs;
      cur_nxt.z = prev.z - ATAN;
    end else begin
      cur_nxt.x = prev.x + ys;
      cur_nxt.y = prev.y - xs;
      cur_nxt.z = prev.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.v <= 1'b0;
    end else if (adv) begin
      cur_r <= cur_nxt;
    end
  end

  assign cur = cur_r;

endmodule

// ===== sv/rmvg_vertex_out.sv =====
// Pairs a segment's two angles; emits six vertices (one if bad), one per cycle unless stalled.
module rmvg_vertex_out
  import rmvg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  trig_t            tail,
  input  logic [RAD_W-1:0] outer_radius,
  input  logic [RAD_W-1:0] inner_radius,
  output logic             take_ready,
  rmvg_out_if.source       out_chan
);

  // first angle of the pending segment
  logic [TRIG_W-1:0] h_s_r, h_c_r;
  logic [U_W-1:0]    h_u_r;

  // segment being emitted
  logic              item_v_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TRIG_W-1:0] s0_r, c0_r, s1_r, c1_r;
  logic [U_W-1:0]    u0_r, u1_r;
  logic [VN_W-1:0]   vnum_r;
  logic              bad_r;

  // product stage
  logic                     b_v_r;
  logic signed [PROD_W-1:0] px_r, py_r;
  logic [VN_W-1:0]          b_vn_r;
  logic [U_W-1:0]           b_u_r;
  logic                     b_tv_r, b_bad_r, b_last_r;

  // output register
  logic             o_v_r;
  logic [VN_W-1:0]  o_vn_r;
  logic [POS_W-1:0] o_x_r, o_y_r;
  logic [U_W-1:0]   o_u_r;
  logic             o_tv_r, o_bad_r, o_last_r;

  logic              adv_out, issue, done, tail_final, load, half_we;
  logic              st, inn;
  logic [TRIG_W-1:0] sel_s, sel_c;
  logic [U_W-1:0]    sel_u;
  logic [RAD_W-1:0]  sel_r;
  logic [POS_W-1:0]  rx;

  assign adv_out    = !o_v_r || out_chan.ready;
  assign issue      = item_v_r && (!b_v_r || adv_out);
  assign done       = bad_r || (slot_r == SLOT_LAST);
  assign take_ready = !item_v_r || (issue && done);
  assign tail_final = tail.m.hi || tail.m.bad;
  assign load       = adv && tail.v && tail_final;
  assign half_we    = adv && tail.v && !tail_final;

  always_comb begin
    st    = slot_step(slot_r);
    inn   = slot_inner(slot_r);
    sel_s = st ? s1_r : s0_r;
    sel_c = st ? c1_r : c0_r;
    sel_u = st ? u1_r : u0_r;
    sel_r = inn ? inner_radius : outer_radius;
    if (bad_r) begin
      sel_s = '0;
      sel_c = '0;
      sel_u = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (half_we) begin
      h_s_r <= tail.s;
      h_c_r <= tail.c;
      h_u_r <= tail.u;
    end
    if (load) begin
      s0_r   <= h_s_r;
      c0_r   <= h_c_r;
      u0_r   <= h_u_r;
      s1_r   <= tail.s;
      c1_r   <= tail.c;
      u1_r   <= tail.u;
      vnum_r <= tail.m.bad ? '0 : tail.m.vnum;
      bad_r  <= tail.m.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      slot_r   <= '0;
    end else if (load) begin
      // a new segment lands in the same cycle the old one retires
      item_v_r <= 1'b1;
      slot_r   <= '0;
    end else if (issue) begin
      if (done) begin
        item_v_r <= 1'b0;
        slot_r   <= '0;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (!b_v_r || adv_out) begin
      b_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      px_r     <= $signed(sel_s) * $signed({1'b0, sel_r});
      py_r     <= $signed(sel_c) * $signed({1'b0, sel_r});
      b_vn_r   <= vnum_r + VN_W'(slot_r);
      b_u_r    <= sel_u;
      b_tv_r   <= inn && !bad_r;
      b_bad_r  <= bad_r;
      b_last_r <= done;
    end
  end

  assign rx = round_pos(px_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv_out) begin
      o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && b_v_r) begin
      o_vn_r   <= b_vn_r;
      o_x_r    <= POS_W'(-rx);
      o_y_r    <= round_pos(py_r);
      o_u_r    <= b_u_r;
      o_tv_r   <= b_tv_r;
      o_bad_r  <= b_bad_r;
      o_last_r <= b_last_r;
    end
  end

  assign out_chan.valid         = o_v_r;
  assign out_chan.vertex_number = o_vn_r;
  assign out_chan.pos_x         = $signed(o_x_r);
  assign out_chan.pos_y         = $signed(o_y_r);
  assign out_chan.tex_u         = o_u_r;
  assign out_chan.tex_v         = o_tv_r;
  assign out_chan.bad_index     = o_bad_r;
  assign out_chan.last          = o_last_r;

endmodule

// ===== sv/ring_mesh_vertex_generator_unit.sv =====
// Top level of the ring mesh vertex generator: issue, divider and CORDIC cell chains.
//
//   channel   direction  transaction
//   in_chan   sink       one segment index
//   out_chan  source     one vertex (six per segment, one on a bad index)
//   cfg_chan  sink       one register write, always ready
//
// A segment sends two angle jobs down the cell chain, a bad index only one; the
// vertex stage then emits six vertices at one per cycle while the output is not
// stalled, so the single vertex multiplier pair sets the rate of a stream of
// segments. All cells advance together and hold while a closing job waits on a
// busy vertex stage; reset clears every valid bit at once.
module ring_mesh_vertex_generator_unit
  import rmvg_pkg::*;
#(
  parameter int INDEX_BITS   = INDEX_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rmvg_in_if.sink   in_chan,
  rmvg_out_if.source out_chan,
  rmvg_cfg_if.sink  cfg_chan
);

  logic [DIV_W-1:0] divisions_r;
  logic [RAD_W-1:0] outer_radius_r, inner_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisions_r    <= DIVISIONS_RST;
      outer_radius_r <= OUTER_RADIUS_RST;
      inner_radius_r <= INNER_RADIUS_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_DIVISIONS:    divisions_r    <= cfg_chan.data[DIV_W-1:0];
        REG_OUTER_RADIUS: outer_radius_r <= cfg_chan.data;
        REG_INNER_RADIUS: inner_radius_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;

  // ---- issue stage ----
  logic                  adv, take_ready, in_take;
  logic                  pend_v_r, pend_hi_r, pend_bad_r;
  logic [INDEX_BITS-1:0] pend_idx_r;
  logic [VN_W-1:0]       pend_vn_r;
  logic [CMP_W-1:0]      k_w;

  assign in_chan.ready = adv && (!pend_v_r || pend_hi_r || pend_bad_r);
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (adv) begin
      if (in_take) begin
        pend_v_r <= 1'b1;
      end else if (pend_hi_r || pend_bad_r) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_take) begin
        pend_idx_r <= in_chan.segment_index;
        pend_hi_r  <= 1'b0;
        pend_bad_r <= CMP_W'(in_chan.segment_index) >= CMP_W'(divisions_r);
        pend_vn_r  <= VN_W'(32'(in_chan.segment_index) * 32'(VERTS_PER_SEG));
      end else begin
        pend_hi_r <= 1'b1;
      end
    end
  end

  assign k_w = CMP_W'(pend_idx_r) + CMP_W'(pend_hi_r);

  // ---- divider chain ----
  div_st_t div_chain [QUO_W+1];

  always_comb begin
    div_chain[0]        = '0;
    div_chain[0].v      = pend_v_r;
    div_chain[0].m.vnum = pend_vn_r;
    div_chain[0].m.hi   = pend_hi_r;
    div_chain[0].m.bad  = pend_bad_r;
    div_chain[0].rem    = k_w[DIV_W-1:0];
  end

  for (genvar gi = 0; gi < QUO_W; gi++) begin : g_div
    rmvg_div_cell #(.FirstCell(gi == 0)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .divisor (divisions_r),
      .prev    (div_chain[gi]),
      .cur     (div_chain[gi+1])
    );
  end

  // ---- phase rounding, then phase to radians ----
  div_st_t          dt;
  logic             ph_v_r;
  meta_t            ph_m_r;
  logic [PH_W-1:0]  ph_r;
  logic [U_W-1:0]   ph_u_r;
  logic             rnd;
  logic [QUO_W-1:0] ph_sum, u_sum;

  assign dt     = div_chain[QUO_W];
  assign rnd    = {dt.rem, 1'b0} >= {1'b0, divisions_r};
  assign ph_sum = dt.quo + QUO_W'(rnd);
  assign u_sum  = dt.quo + QUO_W'(32768);

  logic          zp_v_r;
  meta_t         zp_m_r;
  logic [1:0]    zp_q_r;
  logic [U_W-1:0] zp_u_r;
  logic [45:0]   zp_hi_r, zp_lo_r;
  logic [62:0]   z_sum;

  assign z_sum = {zp_hi_r, 16'b0} + 63'(zp_lo_r) + 63'(32'h4000_0000);

  cor_st_t cor_chain [CORDIC_STEPS+1];
  cor_st_t cor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_v_r  <= 1'b0;
      zp_v_r  <= 1'b0;
      cor_r.v <= 1'b0;
    end else if (adv) begin
      ph_v_r  <= dt.v;
      zp_v_r  <= ph_v_r;
      cor_r.v <= zp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_m_r  <= dt.m;
      ph_r    <= ph_sum[PH_W-1:0];
      ph_u_r  <= u_sum[QUO_W-1:16];
      zp_m_r  <= ph_m_r;
      zp_q_r  <= ph_r[PH_W-1:PH_W-2];
      zp_u_r  <= ph_u_r;
      zp_hi_r <= ph_r[29:0] * PI_Q30_HI;
      zp_lo_r <= ph_r[29:0] * PI_Q30_LO;
      cor_r.m    <= zp_m_r;
      cor_r.quad <= zp_q_r;
      cor_r.u    <= zp_u_r;
      cor_r.x    <= CORDIC_GAIN_Q30;
      cor_r.y    <= '0;
      cor_r.z    <= CW'(z_sum[62:31]);
    end
  end

  assign cor_chain[0] = cor_r;

  for (genvar gc = 0; gc < CORDIC_STEPS; gc++) begin : g_cor
    rmvg_cordic_cell #(.Step(gc)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .prev  (cor_chain[gc]),
      .cur   (cor_chain[gc+1])
    );
  end

  // ---- quadrant fold and rounding to Q1.15 ----
  cor_st_t       ct;
  logic [CW-1:0] s_raw, c_raw;
  trig_t         tail_r;

  assign ct = cor_chain[CORDIC_STEPS];

  always_comb begin
    case (ct.quad)
      2'd0:    begin s_raw = ct.y;  c_raw = ct.x;  end
      2'd1:    begin s_raw = ct.x;  c_raw = -ct.y; end
      2'd2:    begin s_raw = -ct.y; c_raw = -ct.x; end
      default: begin s_raw = -ct.x; c_raw = ct.y;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r.v <= 1'b0;
    end else if (adv) begin
      tail_r <= '{v: ct.v, m: ct.m, s: round_trig(s_raw), c: round_trig(c_raw), u: ct.u};
    end
  end

  // hold the chain only when a closing job waits on a busy vertex stage
  assign adv = !tail_r.v || !(tail_r.m.hi || tail_r.m.bad) || take_ready;

  rmvg_vertex_out u_vertex_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .tail         (tail_r),
    .outer_radius (outer_radius_r),
    .inner_radius (inner_radius_r),
    .take_ready   (take_ready),
    .out_chan     (out_chan)
  );

endmodule

// ===== sv/rmvg_checker.sv =====
// Port-level checks on the result channel of the ring mesh vertex generator.
module rmvg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] vertex_number,
  input logic [16:0] pos_x,
  input logic [16:0] pos_y,
  input logic [16:0] tex_u,
  input logic        tex_v,
  input logic        bad_index,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_index |-> last && vertex_number == 15'd0 && pos_x == 17'd0 &&
    pos_y == 17'd0 && tex_u == 17'd0 && !tex_v)
    else $error("flag result carries geometry");

  a_last_inner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !bad_index && last |-> tex_v)
    else $error("closing vertex is not an inner vertex");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !bad_index |-> tex_u <= 17'h10000 && pos_x != 17'h10000 &&
    pos_y != 17'h10000)
    else $error("vertex field out of range");

endmodule

bind ring_mesh_vertex_generator_unit rmvg_checker u_rmvg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .vertex_number (out_chan.vertex_number),
  .pos_x         (out_chan.pos_x),
  .pos_y         (out_chan.pos_y),
  .tex_u         (out_chan.tex_u),
  .tex_v         (out_chan.tex_v),
  .bad_index     (out_chan.bad_index),
  .last          (out_chan.last)
);

// ===== dv/tb_ring_mesh_vertex_generator_unit.sv =====
// Testbench for ring_mesh_vertex_generator_unit: directed table, random segments, vertex checker.
module tb_ring_mesh_vertex_generator_unit;
  import rmvg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [VN_W-1:0]  vnum;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [U_W-1:0]   u;
    logic             v;
    logic             bad;
    logic             last;
  } vertex_t;

  typedef struct {
    logic [11:0] idx;
    bit          lit_bad;  // expected flag transaction typed in directly
  } seg_row_t;

  localparam int HOLD_LEN  = 300;
  localparam int DRAIN_LEN = 80;
  localparam int WDOG_LIM  = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam longint ARCTAN[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rmvg_in_if #(.IndexBits(12)) in_if();
  rmvg_out_if out_if();
  rmvg_cfg_if cfg_if();

  ring_mesh_vertex_generator_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if), .cfg_chan(cfg_if)
  );

  always #5 clk = ~clk;

  logic [DIV_W-1:0] divs_q;
  logic [RAD_W-1:0] r_out_q;
  logic [RAD_W-1:0] r_in_q;
  vertex_t          pending_verts[$];
  idle_mode_t       mode = IDLE_NONE;
  int               errors = 0;
  int               idle_cnt = 0;
  bit               hold_req = 0;
  int               hold_left = 0;
  bit               lit_next = 1'b0;

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t vertex field %s: got %0d, want %0d", $time, field, got, want);
    errors++;
  endtask

  // sin/cos of step k out of d, Q1.15 clamped to +-1.0
  function automatic void angle_trig(longint unsigned k, longint unsigned d,
                                     output longint s, output longint c);
    longint unsigned ph, rest;
    longint x, y, z, xs, ys;
    int quad;
    ph = ((k << 33) + d) / (2 * d);
    ph &= 64'hFFFF_FFFF;
    quad = int'(ph >> 30);
    rest = ph & 64'h3FFF_FFFF;
    z = longint'((rest * 64'd3373259426 + (64'd1 << 30)) >> 31);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ARCTAN[i];
      end else begin
        x += ys; y -= xs; z += ARCTAN[i];
      end
    end
    case (quad)
      0: begin s = y;  c = x;  end
      1: begin s = x;  c = -y; end
      2: begin s = -y; c = -x; end
      default: begin s = -x; c = y; end
    endcase
    s = (s + 16384) >>> 15;
    c = (c + 16384) >>> 15;
    if (s > 32768) s = 32768;
    if (s < -32768) s = -32768;
    if (c > 32768) c = 32768;
    if (c < -32768) c = -32768;
  endfunction

  function automatic longint to_q88(longint t, longint r);
    longint p;
    p = (t * r + 16384) >>> 15;
    if (p > 65535) p = 65535;
    if (p < -65535) p = -65535;
    return p;
  endfunction

  function automatic vertex_t flag_vertex();
    vertex_t e;
    e = '{vnum: '0, px: '0, py: '0, u: '0, v: 1'b0, bad: 1'b1, last: 1'b1};
    return e;
  endfunction

  // Push the six vertices (or the flag) that one segment yields
  task automatic predict_segment(logic [11:0] idx);
    longint unsigned d, k;
    longint s[2], c[2];
    longint unsigned u[2];
    vertex_t e;
    bit st, inr;
    longint r;
    d = divs_q;
    if (d == 0 || idx >= d) begin
      pending_verts.push_back(flag_vertex());
    end else begin
      for (int j = 0; j < 2; j++) begin
        k = idx + j;
        angle_trig(k, d, s[j], c[j]);
        u[j] = ((k << 17) + d) / (2 * d);
      end
      for (int slot = 0; slot < 6; slot++) begin
        st  = (slot == 1 || slot == 4 || slot == 5);
        inr = (slot == 2 || slot == 3 || slot == 5);
        r = inr ? r_in_q : r_out_q;
        e.vnum = VN_W'(idx * 6 + slot);
        e.px   = POS_W'(-to_q88(s[st], r));
        e.py   = POS_W'(to_q88(c[st], r));
        e.u    = U_W'(u[st]);
        e.v    = inr;
        e.bad  = 1'b0;
        e.last = (slot == 5);
        pending_verts.push_back(e);
      end
    end
  endtask

  // Predict on input transactions, check output transactions, watch for a hang
  always @(posedge clk) begin
    vertex_t w;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_LIM) begin
        $display("ring_mesh_vertex_generator_unit: mismatch");
        $finish;
      end
      if (in_if.valid && in_if.ready) begin
        if (lit_next)
          pending_verts.push_back(flag_vertex());
        else
          predict_segment(in_if.segment_index);
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_verts.size() == 0) begin
          report_mismatch("unexpected vertex_number", out_if.vertex_number, -1);
        end else begin
          w = pending_verts.pop_front();
          if (out_if.vertex_number !== w.vnum)
            report_mismatch("vertex_number", out_if.vertex_number, w.vnum);
          if (out_if.pos_x !== w.px)
            report_mismatch("pos_x", $signed(out_if.pos_x), $signed(w.px));
          if (out_if.pos_y !== w.py)
            report_mismatch("pos_y", $signed(out_if.pos_y), $signed(w.py));
          if (out_if.tex_u !== w.u) report_mismatch("tex_u", out_if.tex_u, w.u);
          if (out_if.tex_v !== w.v) report_mismatch("tex_v", out_if.tex_v, w.v);
          if (out_if.bad_index !== w.bad)
            report_mismatch("bad_index", out_if.bad_index, w.bad);
          if (out_if.last !== w.last) report_mismatch("last", out_if.last, w.last);
        end
      end
    end
  end

  // Result side: random stalls per mode, long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (mode == IDLE_RECV)
      out_if.ready <= ($urandom_range(99) >= 65);
    else if (mode == IDLE_BOTH)
      out_if.ready <= ($urandom_range(99) >= 17);
    else
      out_if.ready <= 1'b1;
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_DIVISIONS:    divs_q  = data[DIV_W-1:0];
      REG_OUTER_RADIUS: r_out_q = data;
      REG_INNER_RADIUS: r_in_q  = data;
      default: ;
    endcase
  endtask

  task automatic send_segment(logic [11:0] idx);
    int pct;
    pct = (mode == IDLE_SEND) ? 65 : (mode == IDLE_BOTH) ? 17 : 0;
    while ($urandom_range(99) < pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.segment_index <= idx;
    do @(posedge clk); while (!in_if.ready);
  endtask

  function automatic logic [11:0] pick_index();
    int d;
    d = divs_q > 4096 ? 4096 : divs_q;
    if (d == 0 || $urandom_range(99) < 15)
      return 12'($urandom_range(4095));
    return 12'($urandom_range(d - 1));
  endfunction

  // Pause the sender until every vertex is back, then let the pipe settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_verts.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);
  endtask

  task automatic random_phase(idle_mode_t m, int n);
    mode = m;
    repeat (n) send_segment(pick_index());
    drain();
  endtask

  seg_row_t seg_table[] = '{
    '{12'd0, 0}, '{12'd1, 0}, '{12'd31, 0}, '{12'd32, 1}, '{12'd4095, 1},
    '{12'd2048, 1}, '{12'd8, 0}, '{12'd16, 0}, '{12'd24, 0}, '{12'd33, 1}};
  logic [11:0] wide_idx[] = '{12'd0, 12'd4095, 12'd1024, 12'd2048, 12'd3072,
                              12'd1365, 12'd2730};

  initial begin
    in_if.valid = 1'b0;
    in_if.segment_index = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    divs_q  = DIVISIONS_RST;
    r_out_q = OUTER_RADIUS_RST;
    r_in_q  = INNER_RADIUS_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: flag transactions are known outright
    foreach (seg_table[i]) begin
      lit_next <= seg_table[i].lit_bad;
      send_segment(seg_table[i].idx);
    end
    lit_next <= 1'b0;
    drain();

    write_reg(REG_DIVISIONS, 16'd4096);
    write_reg(REG_OUTER_RADIUS, 16'hFFFF);
    write_reg(REG_INNER_RADIUS, 16'h0000);
    foreach (wide_idx[i]) send_segment(wide_idx[i]);
    random_phase(IDLE_NONE, 15);

    write_reg(REG_DIVISIONS, 16'd1);
    write_reg(REG_OUTER_RADIUS, 16'h0000);
    write_reg(REG_INNER_RADIUS, 16'hFFFF);
    random_phase(IDLE_SEND, 15);

    write_reg(REG_DIVISIONS, 16'd0);
    random_phase(IDLE_RECV, 8);

    write_reg(REG_DIVISIONS, 16'hFFFF);  // upper bits dropped: 8191 segments
    write_reg(REG_OUTER_RADIUS, 16'($urandom_range(65535)));
    write_reg(REG_INNER_RADIUS, 16'($urandom_range(65535)));
    random_phase(IDLE_BOTH, 20);

    write_reg(REG_DIVISIONS, 16'($urandom_range(64, 1)));
    write_reg(REG_OUTER_RADIUS, 16'($urandom_range(65535)));
    write_reg(REG_INNER_RADIUS, 16'($urandom_range(65535)));
    write_reg(REG_UNUSED, 16'($urandom_range(65535)));
    // Hold the result side so the pipe backs up into the input
    hold_req = 1;
    random_phase(IDLE_NONE, 25);

    write_reg(REG_DIVISIONS, 16'd32);
    write_reg(REG_OUTER_RADIUS, 16'd256);
    write_reg(REG_INNER_RADIUS, 16'd128);
    random_phase(IDLE_RECV, 12);
    random_phase(IDLE_SEND, 13);

    if (errors == 0)
      $display("ring_mesh_vertex_generator_unit: match");
    else
      $display("ring_mesh_vertex_generator_unit: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rmvg_pkg.sv
sv/rmvg_if.sv
sv/rmvg_div_cell.sv
sv/rmvg_cordic_cell.sv
sv/rmvg_vertex_out.sv
sv/ring_mesh_vertex_generator_unit.sv
sv/rmvg_checker.sv
dv/tb_ring_mesh_vertex_generator_unit.sv
